### sv/tdf_pkg.sv
// Shared constants and types of the trial-division factorizer.
package tdf_pkg;

   // Default build-time choices.
   localparam int VALUE_BITS_DEF  = 32;
   localparam int PRIME_LIMIT_DEF = 65536;

   // Fixed field widths on the streams.
   localparam int MAGNITUDE_BITS = 32;
   localparam int FACTOR_BITS    = 32;

   // Quotient bits retired by the divider in one cycle.
   localparam int DIV_DIGITS = 4;

   // Status returned by the divider to the sequencer.
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

### sv/tdf_divider.sv
// Iterative restoring divider, four quotient bits per cycle, shared by all trials.
module tdf_divider #(
   parameter int VALUE_BITS   = tdf_pkg::VALUE_BITS_DEF,
   parameter int DIVISOR_BITS = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_BITS-1:0]      dividend,
   input  logic [DIVISOR_BITS-1:0]    divisor,
   output logic [VALUE_BITS-1:0]      quotient,
   output tdf_pkg::div_status_type    status
);
   import tdf_pkg::*;

   localparam int CYCLES   = (VALUE_BITS + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int PAD_BITS = CYCLES * DIV_DIGITS;
   localparam int CNT_BITS = $clog2(CYCLES + 1);

   logic [DIVISOR_BITS-1:0] part_ff, part_in;
   logic [PAD_BITS-1:0]     quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0] divisor_ff;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   // Several restoring steps: shift in the next dividend bit, subtract where it fits.
   always_comb begin
      logic [DIVISOR_BITS:0]   trial;
      logic [DIVISOR_BITS-1:0] part_v;
      logic [PAD_BITS-1:0]     quo_v;
      part_v = part_ff;
      quo_v  = quo_ff;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         trial = {part_v, quo_v[PAD_BITS-1]};
         quo_v = {quo_v[PAD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial    = trial - {1'b0, divisor_ff};
            quo_v[0] = 1'b1;
         end
         part_v = trial[DIVISOR_BITS-1:0];
      end
      part_in = part_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         part_in = '0;
         quo_in  = PAD_BITS'(dividend);
         cnt_in  = CNT_BITS'(CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         part_in = part_v;
         quo_in  = quo_v;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      part_ff <= part_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   // Results stay put until the next start.
   assign quotient        = quo_ff[VALUE_BITS-1:0];
   assign status.done     = done_ff;
   assign status.rem_zero = (part_ff == '0);

endmodule

### sv/trial_division_factorizer_unit.sv
// Top level of the trial-division factorizer: sequencer, trial divisor wheel and result register.
//
// Channel  Dir  Handshake              Contents
// req_     in   req_tvalid/req_tready  tdata: magnitude; tuser: negative
// rsp_     out  rsp_tvalid/rsp_tready  tdata: factor; tuser: minus_one; tlast: last
//
// One number occupies the block from its transfer until its last factor is stored.
// Trial divisors (2, 3, then 6k-1 and 6k+1) run on the shared divider, four quotient bits a cycle.
// req_tready is high only while the sequencer is idle; a stalled result holds the sequencer.
// Reset is synchronous and clears the sequencer and the result valid flag.
module trial_division_factorizer_unit #(
   parameter int VALUE_BITS  = tdf_pkg::VALUE_BITS_DEF,
   parameter int PRIME_LIMIT = tdf_pkg::PRIME_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdf_pkg::MAGNITUDE_BITS-1:0] req_tdata,   // [31:0] magnitude
   input  logic                               req_tuser,   // [0] negative
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tdf_pkg::FACTOR_BITS-1:0]    rsp_tdata,   // [31:0] factor
   output logic                               rsp_tuser,   // [0] minus_one
   output logic                               rsp_tlast
);
   import tdf_pkg::*;

   localparam int CAND_BITS = $clog2(PRIME_LIMIT) + 1;
   localparam int SQ_BITS   = 2 * CAND_BITS;
   localparam int CMP_BITS  = (SQ_BITS > VALUE_BITS) ? SQ_BITS : VALUE_BITS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SIGN   = 3'd1;
   localparam logic [2:0] S_SMALL  = 3'd2;
   localparam logic [2:0] S_SQUARE = 3'd3;
   localparam logic [2:0] S_TEST   = 3'd4;
   localparam logic [2:0] S_DIVIDE = 3'd5;
   localparam logic [2:0] S_DECIDE = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_BITS-1:0]  rem_ff, rem_in;
   logic                   neg_ff, neg_in;
   logic [CAND_BITS-1:0]   cand_ff, cand_in;
   logic                   wheel_ff, wheel_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;

   logic                   rsp_valid_ff;
   logic [FACTOR_BITS-1:0] rsp_factor_ff;
   logic                   rsp_minus_ff;
   logic                   rsp_last_ff;

   logic                   slot_free;
   logic                   put_valid;
   logic [FACTOR_BITS-1:0] put_factor;
   logic                   put_minus;
   logic                   put_last;

   logic                   div_start;
   logic [VALUE_BITS-1:0]  div_quotient;
   div_status_type         div_st;

   // Shared divider for every trial.
   tdf_divider #(
      .VALUE_BITS   (VALUE_BITS),
      .DIVISOR_BITS (CAND_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rem_ff),
      .divisor  (cand_ff),
      .quotient (div_quotient),
      .status   (div_st)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      cand_in    = cand_ff;
      wheel_in   = wheel_ff;
      sq_in      = sq_ff;
      div_start  = 1'b0;
      put_valid  = 1'b0;
      put_factor = FACTOR_BITS'(rem_ff);
      put_minus  = 1'b0;
      put_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rem_in   = req_tdata[VALUE_BITS-1:0];
               neg_in   = req_tuser;
               cand_in  = CAND_BITS'(2);
               wheel_in = 1'b0;
               state_in = req_tuser ? S_SIGN : S_SMALL;
            end
         end
         S_SIGN: begin
            // Leading minus-one marker; alone when the magnitude is one.
            put_factor = FACTOR_BITS'(1);
            put_minus  = 1'b1;
            put_last   = (rem_ff == VALUE_BITS'(1));
            if (slot_free) begin
               put_valid = 1'b1;
               state_in  = put_last ? S_IDLE : S_SMALL;
            end
         end
         S_SMALL: begin
            // Zero and one are reported as they are.
            if (rem_ff <= VALUE_BITS'(1)) begin
               if (slot_free) begin
                  put_valid = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            sq_in    = SQ_BITS'(cand_ff) * SQ_BITS'(cand_ff);
            state_in = S_TEST;
         end
         S_TEST: begin
            // Cofactor goes out whole once the divisor passes its root (prime) or hits the limit.
            if (cand_ff >= CAND_BITS'(PRIME_LIMIT) ||
                CMP_BITS'(sq_ff) > CMP_BITS'(rem_ff)) begin
               if (slot_free) begin
                  put_valid = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_st.done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (div_st.rem_zero) begin
               // Divisor found: report it and try the same divisor again.
               put_factor = FACTOR_BITS'(cand_ff);
               put_last   = (div_quotient == VALUE_BITS'(1));
               if (slot_free) begin
                  put_valid = 1'b1;
                  rem_in    = div_quotient;
                  state_in  = put_last ? S_IDLE : S_TEST;
               end
            end else begin
               // Step along the 2, 3, 5, 7, 11, 13 ... wheel.
               if (cand_ff == CAND_BITS'(2)) begin
                  cand_in = CAND_BITS'(3);
               end else if (cand_ff == CAND_BITS'(3)) begin
                  cand_in = CAND_BITS'(5);
               end else begin
                  cand_in  = cand_ff + (wheel_ff ? CAND_BITS'(4) : CAND_BITS'(2));
                  wheel_in = !wheel_ff;
               end
               state_in = S_SQUARE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (put_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      cand_ff  <= cand_in;
      wheel_ff <= wheel_in;
      sq_ff    <= sq_in;
      if (put_valid) begin
         rsp_factor_ff <= put_factor;
         rsp_minus_ff  <= put_minus;
         rsp_last_ff   <= put_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_factor_ff;
   assign rsp_tuser  = rsp_minus_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The block takes one number at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a number was still in work");

   // The divider reports completion only to a waiting sequencer.
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside a division");

   // Trial divisors are 2 or odd.
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TEST |-> cand_ff[0] || cand_ff == CAND_BITS'(2))
      else $error("even trial divisor above two");

   // Trials only run on a cofactor above one.
   a_cofactor_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TEST |-> rem_ff > VALUE_BITS'(1))
      else $error("trial on a finished cofactor");

   // A negative number always opens with its marker.
   a_marker_first: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> state_ff == S_SIGN && neg_ff)
      else $error("negative number did not start with the sign marker");

endmodule

### test/tdf_result_checker.sv
// Checker for the trial-division factoriser: watches both channels, predicts and compares factors.
module tdf_result_checker #(
   parameter int VALUE_BITS  = tdf_pkg::VALUE_BITS_DEF,
   parameter int PRIME_LIMIT = tdf_pkg::PRIME_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [tdf_pkg::MAGNITUDE_BITS-1:0] req_tdata,   // [31:0] magnitude
   input  logic                               req_tuser,   // [0] negative
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tdf_pkg::FACTOR_BITS-1:0]    rsp_tdata,   // [31:0] factor
   input  logic                               rsp_tuser,   // [0] minus_one
   input  logic                               rsp_tlast,
   output int unsigned                        errors,
   output int unsigned                        pending,
   output int unsigned                        numbers,
   output int unsigned                        results,
   output int unsigned                        markers
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] VALUE_MASK = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF
                                                           : (32'd1 << VALUE_BITS) - 32'd1;

   // One predicted factor as it should leave the block.
   typedef struct packed {
      logic [31:0] factor;
      logic        minus_one;
      logic        last;
   } factor_result_type;

   factor_result_type factor_queue[$];
   int unsigned       trial_primes[$];

   // Build the table of trial primes with a sieve; the counters start at zero as two-state values.
   initial begin : build_primes
      bit              crossed [PRIME_LIMIT];
      longint unsigned multiple;
      for (int unsigned a = 2; a < PRIME_LIMIT; a++) begin
         if (!crossed[a]) begin
            trial_primes.push_back(a);
            for (multiple = longint'(a) * a; multiple < PRIME_LIMIT; multiple += a) begin
               crossed[multiple] = 1'b1;
            end
         end
      end
   end

   function automatic void add_factor(input logic [31:0] factor, input logic minus_one,
                                      input logic last);
      factor_result_type entry;
      entry.factor    = factor;
      entry.minus_one = minus_one;
      entry.last      = last;
      factor_queue.push_back(entry);
   endfunction

   // Queue the factors that one accepted number should produce, smallest first.
   function automatic void factorise_number(input logic [31:0] magnitude, input logic negative);
      logic [31:0] cofactor;
      logic [31:0] divisor;
      int unsigned position;
      cofactor = magnitude & VALUE_MASK;
      if (negative) begin
         add_factor(32'd1, 1'b1, cofactor == 32'd1);
         if (cofactor == 32'd1) return;
      end
      if (cofactor <= 32'd1) begin
         add_factor(cofactor, 1'b0, 1'b1);
         return;
      end
      position = 0;
      while (cofactor > 32'd1) begin
         if (position >= trial_primes.size()) begin
            // Table used up: what is left is emitted as a single factor.
            add_factor(cofactor, 1'b0, 1'b1);
            cofactor = 32'd1;
         end else begin
            divisor = trial_primes[position];
            if (64'(divisor) * 64'(divisor) > 64'(cofactor)) begin
               // No divisor up to the square root is left, so the cofactor is prime.
               add_factor(cofactor, 1'b0, 1'b1);
               cofactor = 32'd1;
            end else begin
               while (cofactor > 32'd1 && cofactor % divisor == 32'd0) begin
                  cofactor = cofactor / divisor;
                  add_factor(divisor, 1'b0, cofactor == 32'd1);
               end
               position++;
            end
         end
      end
   endfunction

   // Predict on each number transfer and compare each result transfer with the oldest prediction.
   always @(posedge clock) begin : watch
      factor_result_type want;
      int unsigned       bad;
      bad = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            factorise_number(req_tdata, req_tuser);
            numbers <= numbers + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results <= results + 1;
            if (rsp_tuser) markers <= markers + 1;
            if (factor_queue.size() == 0) begin
               $error("factor %0d (minus_one %0b, last %0b) arrived with nothing expected",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               bad++;
            end else begin
               want = factor_queue.pop_front();
               if (rsp_tdata !== want.factor) begin
                  $error("factor: expected %0d, got %0d", want.factor, rsp_tdata);
                  bad++;
               end
               if (rsp_tuser !== want.minus_one) begin
                  $error("minus_one: expected %0b, got %0b", want.minus_one, rsp_tuser);
                  bad++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  bad++;
               end
            end
         end
      end
      errors  <= errors + bad;
      pending <= factor_queue.size();
   end

endmodule

### test/tb_trial_division_factorizer_unit.sv
// Testbench top for the trial-division factoriser: clock, reset, stimulus, idling and verdict.
module tb_trial_division_factorizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_NUMBERS = 100;
   localparam int unsigned QUIET_LIMIT    = 2_000_000;
   localparam int unsigned SETTLE_CYCLES  = 50;

   // Hand-picked numbers: bit 32 is the sign, the low 32 bits the magnitude.
   localparam logic [32:0] CORNER_CASES [20] = '{
      {1'b0, 32'd0},          {1'b1, 32'd0},          {1'b0, 32'd1},
      {1'b1, 32'd1},          {1'b0, 32'd2},          {1'b1, 32'd3},
      {1'b0, 32'd4},          {1'b1, 32'd6},          {1'b0, 32'd25},
      {1'b1, 32'd49},         {1'b0, 32'd30},         {1'b0, 32'h8000_0000},
      {1'b1, 32'h8000_0000},  {1'b1, 32'hFFFF_FFFF},  {1'b0, 32'd65521},
      {1'b0, 32'd65537},      {1'b1, 32'd65536},      {1'b0, 32'd131042},
      {1'b0, 32'd4293001441}, {1'b1, 32'd4294967291}
   };

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [tdf_pkg::MAGNITUDE_BITS-1:0] req_tdata  = '0;   // [31:0] magnitude
   logic                               req_tuser  = 1'b0; // [0] negative
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [tdf_pkg::FACTOR_BITS-1:0]    rsp_tdata;         // [31:0] factor
   logic                               rsp_tuser;         // [0] minus_one
   logic                               rsp_tlast;

   int unsigned errors;
   int unsigned pending;
   int unsigned numbers;
   int unsigned results;
   int unsigned markers;

   bit          calm         = 1'b0;
   logic        rsp_taken    = 1'b0;
   int unsigned rsp_hold     = 0;
   int unsigned quiet_cycles = 0;

   trial_division_factorizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tdf_result_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending),
      .numbers    (numbers),
      .results    (results),
      .markers    (markers)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Result side: after each transfer, hold tready low for a random number of cycles.
   always @(posedge clock) rsp_taken <= rsp_tvalid && rsp_tready;

   always @(negedge clock) begin
      if (rsp_taken) rsp_hold = calm ? 0 : $urandom_range(0, 7);
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Give up when no transfer has happened for far longer than the slowest number needs.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL trial_division_factorizer_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one number after a random gap and wait for its transfer; entered at a falling edge.
   task automatic send_number(input logic [31:0] magnitude, input logic negative);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         req_tuser  <= 1'($urandom());
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= magnitude;
      req_tuser  <= negative;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending != 0) @(negedge clock);
   endtask

   // Product of random integers up to a bound, kept within 32 bits.
   function automatic logic [31:0] smooth_number(input int unsigned bound,
                                                 input int unsigned count);
      logic [63:0] product;
      int unsigned term;
      product = 64'd1;
      repeat (count) begin
         term = $urandom_range(2, bound);
         if (product * term <= 64'hFFFF_FFFF) product = product * term;
      end
      return product[31:0];
   endfunction

   // Random magnitude: mostly numbers whose factors are small enough to finish quickly.
   function automatic logic [31:0] pick_magnitude();
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 30) return $urandom_range(0, 5000);
      else if (kind < 55) return smooth_number(40, $urandom_range(1, 31));
      else if (kind < 75) return smooth_number(2000, $urandom_range(1, 4));
      else if (kind < 90) return 32'($urandom_range(1, 255)) << $urandom_range(0, 24);
      else if (kind < 95) return $urandom_range(0, 32'h000F_FFFF);
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'h8000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Stimulus: corner cases, a full drain, then random numbers with calm stretches and a drain halfway.
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      foreach (CORNER_CASES[k]) send_number(CORNER_CASES[k][31:0], CORNER_CASES[k][32]);
      req_tvalid <= 1'b0;
      wait_for_drain();
      for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
         calm = (n % 40) >= 30;
         if (n == RANDOM_NUMBERS / 2) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
         send_number(pick_magnitude(), 1'($urandom()));
      end
      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Factorised %0d numbers into %0d results, %0d of them sign markers; %0d mismatches.",
               numbers, results, markers, errors);
      $display("Covered zero and one of both signs, 32-result powers of two, the top table prime,");
      $display("its square, and a prime cofactor beyond the table.");
      if (errors == 0) begin
         $display("PASS trial_division_factorizer_unit");
      end else begin
         $display("FAIL trial_division_factorizer_unit");
      end
      $finish;
   end

endmodule
